// ----- sv/key_matrix_to_nkro_report_defines.svh -----
// Assertion macros for the keyboard matrix to NKRO report block.
// Used by the top level only; they assume its aclk and aresetn.
`ifndef KEY_MATRIX_TO_NKRO_REPORT_DEFINES_SVH
`define KEY_MATRIX_TO_NKRO_REPORT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMNR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KMNR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kmnr_pkg.sv -----
// Shared constants and types for the keyboard matrix to NKRO report block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package kmnr_pkg;

    // Sizing of the block.
    localparam int NUM_CHIPS    = 8;
    localparam int NUM_LAYERS   = 2;
    localparam int REPORT_BYTES = 32;

    // Field widths fixed by the interface.
    localparam int MAX_CHIPS = 8;
    localparam int CHIP_W    = 3;
    localparam int POS_W     = 6;
    localparam int CODE_W    = 8;
    localparam int IDX_W     = 5;
    localparam int MAP_AW    = 1 + POS_W;
    localparam int MAP_DEPTH = NUM_LAYERS * (1 << POS_W);
    localparam int REPORT_AW = $clog2(REPORT_BYTES);
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    // Request types.
    localparam logic [1:0] REQ_KEYMAP_WRITE = 2'd0;
    localparam logic [1:0] REQ_SAMPLE       = 2'd1;
    localparam logic [1:0] REQ_FRAME_END    = 2'd2;

    // Key classes.
    localparam logic [1:0] CLASS_STANDARD = 2'd0;
    localparam logic [1:0] CLASS_MODIFIER = 2'd1;
    localparam logic [1:0] CLASS_OTHER    = 2'd2;

    // Keycode ranges.
    localparam logic [CODE_W-1:0] STD_FIRST = 8'h04;
    localparam logic [CODE_W-1:0] STD_LAST  = 8'hA4;
    localparam logic [4:0]        MOD_GROUP = 5'b11100;  // 0xE0 to 0xE7
    localparam logic [IDX_W-1:0]  STD_INDEX_OFFSET = 5'd2;

    // Register addresses.
    localparam logic [PADDR_W-1:0] ADDR_FN_POSITION = 2'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic map_we;
        logic acc_we;
        logic frame_start;
        logic chip_inc;
        logic issue;
        logic emit;
    } kmnr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic any_diff;
        logic chip_diff_zero;
    } kmnr_status_t;

endpackage

`default_nettype wire

// ----- sv/kmnr_ctrl.sv -----
// Controller of the keyboard matrix to NKRO report block.
// Sequences requests and the frame-end walk; uses kmnr_pkg.
`default_nettype none

module kmnr_ctrl
    import kmnr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_req_type,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire kmnr_status_t status,
    output kmnr_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOKUP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_xfer;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // Next state, commands and output valid.
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (s_req_type)
                        REQ_KEYMAP_WRITE: cmd.map_we = 1'b1;
                        REQ_SAMPLE:       cmd.acc_we = 1'b1;
                        REQ_FRAME_END: begin
                            cmd.frame_start = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // End the walk when no change is left; skip chips without changes; start a keymap read otherwise.
                if (!status.any_diff) begin
                    state_next = ST_IDLE;
                end else if (status.chip_diff_zero) begin
                    cmd.chip_inc = 1'b1;
                end else begin
                    cmd.issue  = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // Update the report once the output register is free.
                if (out_free) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = status.any_diff ? ST_SCAN : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/kmnr_datapath.sv -----
// Datapath of the keyboard matrix to NKRO report block: debounce
// accumulators, previous frame, keymap memory, report bytes and result
// register. Uses kmnr_pkg.
`default_nettype none

module kmnr_datapath
    import kmnr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire kmnr_cmd_t         cmd,
    output kmnr_status_t           status,
    input  wire logic [POS_W-1:0]  fn_position,
    input  wire logic [CHIP_W-1:0] s_chip_index,
    input  wire logic [7:0]        s_sample_byte,
    input  wire logic              s_first_read,
    input  wire logic              s_map_layer,
    input  wire logic [POS_W-1:0]  s_map_position,
    input  wire logic [CODE_W-1:0] s_map_keycode,
    output logic [CODE_W-1:0]      m_keycode,
    output logic                   m_press,
    output logic [1:0]             m_key_class,
    output logic [IDX_W-1:0]       m_report_index,
    output logic [7:0]             m_report_value,
    output logic                   m_last
);

    // Index of the highest set bit, which is the first scan position.
    function automatic logic [2:0] top_bit(input logic [7:0] v);
        logic [2:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) r = 3'(i);
        end
        return r;
    endfunction

    logic [7:0]        acc_reg  [MAX_CHIPS];
    logic [7:0]        prev_reg [MAX_CHIPS];
    logic [7:0]        diff_reg [MAX_CHIPS];
    logic [7:0]        report_reg [REPORT_BYTES];
    logic [CODE_W-1:0] keymap_mem [MAP_DEPTH];

    logic [CHIP_W-1:0] chip_reg;
    logic              layer_reg;
    logic              down_reg;
    logic [CODE_W-1:0] rd_data_reg;

    logic [CODE_W-1:0] keycode_reg;
    logic              press_reg;
    logic [1:0]        key_class_reg;
    logic [IDX_W-1:0]  report_index_reg;
    logic [7:0]        report_value_reg;
    logic              last_reg;

    logic [7:0]        now_vec [MAX_CHIPS];
    logic              fn_hit;
    logic [7:0]        chip_diff;
    logic [2:0]        pick_bit;
    logic [MAP_AW-1:0] rd_addr;
    logic              acc_chip_ok;
    logic              any_diff;

    logic              is_std;
    logic              is_mod;
    logic [1:0]        code_class;
    logic [IDX_W-1:0]  rpt_idx;
    logic [7:0]        bit_mask;
    logic [7:0]        rpt_old;
    logic [7:0]        rpt_new;

    // Pressed bits of this frame and the fn key layer select.
    always_comb begin
        for (int c = 0; c < MAX_CHIPS; c++) begin
            now_vec[c] = (c < NUM_CHIPS) ? ~acc_reg[c] : 8'h00;
        end
        fn_hit = now_vec[fn_position[POS_W-1:3]][~fn_position[2:0]];
    end

    // Walk status.
    always_comb begin
        any_diff = 1'b0;
        for (int c = 0; c < MAX_CHIPS; c++) begin
            any_diff = any_diff | (|diff_reg[c]);
        end
    end

    assign chip_diff             = diff_reg[chip_reg];
    assign status.any_diff       = any_diff;
    assign status.chip_diff_zero = (chip_diff == 8'h00);
    assign pick_bit              = top_bit(chip_diff);
    assign rd_addr               = {layer_reg, chip_reg, ~pick_bit};
    assign acc_chip_ok           = (int'(s_chip_index) < NUM_CHIPS);

    // Accumulators, previous frame and pending changes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < MAX_CHIPS; c++) begin
                acc_reg[c]  <= '0;
                prev_reg[c] <= '0;
                diff_reg[c] <= '0;
            end
            chip_reg  <= '0;
            layer_reg <= 1'b0;
        end else begin
            if (cmd.acc_we && acc_chip_ok) begin
                acc_reg[s_chip_index] <= s_first_read ? s_sample_byte
                                                      : (acc_reg[s_chip_index] & s_sample_byte);
            end
            if (cmd.frame_start) begin
                for (int c = 0; c < MAX_CHIPS; c++) begin
                    diff_reg[c] <= now_vec[c] ^ prev_reg[c];
                    prev_reg[c] <= now_vec[c];
                end
                chip_reg  <= '0;
                layer_reg <= fn_hit;
            end
            if (cmd.chip_inc) begin
                chip_reg <= chip_reg + 1'b1;
            end
            if (cmd.issue) begin
                diff_reg[chip_reg][pick_bit] <= 1'b0;
            end
        end
    end

    // Keymap memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.map_we) begin
            keymap_mem[{s_map_layer, s_map_position}] <= s_map_keycode;
        end
        if (cmd.issue) begin
            rd_data_reg <= keymap_mem[rd_addr];
            down_reg    <= prev_reg[chip_reg][pick_bit];
        end
    end

    // Classification and report byte update of the looked-up key.
    always_comb begin
        is_std   = (rd_data_reg >= STD_FIRST) && (rd_data_reg <= STD_LAST);
        is_mod   = (rd_data_reg[7:3] == MOD_GROUP);
        bit_mask = 8'h01 << rd_data_reg[2:0];
        if (is_std) begin
            code_class = CLASS_STANDARD;
            rpt_idx    = rd_data_reg[7:3] + STD_INDEX_OFFSET;
        end else if (is_mod) begin
            code_class = CLASS_MODIFIER;
            rpt_idx    = '0;
        end else begin
            code_class = CLASS_OTHER;
            rpt_idx    = '0;
        end
        rpt_old = report_reg[rpt_idx[REPORT_AW-1:0]];
        rpt_new = down_reg ? (rpt_old | bit_mask) : (rpt_old & ~bit_mask);
    end

    // Report bytes, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REPORT_BYTES; i++) begin
                report_reg[i] <= '0;
            end
        end else if (cmd.emit && (code_class != CLASS_OTHER)) begin
            report_reg[rpt_idx[REPORT_AW-1:0]] <= rpt_new;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            keycode_reg      <= rd_data_reg;
            press_reg        <= down_reg;
            key_class_reg    <= code_class;
            report_index_reg <= rpt_idx;
            report_value_reg <= (code_class == CLASS_OTHER) ? 8'h00 : rpt_new;
            last_reg         <= !any_diff;
        end
    end

    assign m_keycode      = keycode_reg;
    assign m_press        = press_reg;
    assign m_key_class    = key_class_reg;
    assign m_report_index = report_index_reg;
    assign m_report_value = report_value_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

// ----- sv/key_matrix_to_nkro_report.sv -----
// Top level of the keyboard matrix to NKRO report block: configuration
// register, controller and datapath. Uses kmnr_pkg, kmnr_ctrl, kmnr_datapath
// and the assertion macros in key_matrix_to_nkro_report_defines.svh.
`default_nettype none
`include "key_matrix_to_nkro_report_defines.svh"

// Turns active-low shift-register samples into press and release results and
// keeps an NKRO report up to date. A keymap write or a sample byte is stored
// when it is taken. A frame end first compares the frame with the previous
// one; a frame without any change then ends the walk with no result.
// Otherwise the walk steps from one chip to the next, up to the chip of the
// last change, and handles each changed key with a keymap memory read, then
// the report byte update into the result register, waiting while the result
// register has not been taken; no new request is taken until the walk is
// done.
// Results come out chips in ascending order and MSB-first within a chip, and
// the final result of a frame has last set. Register 0 at byte address 0 holds
// the fn key position, which selects keymap layer 1 when that key is pressed.
module key_matrix_to_nkro_report
    import kmnr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    // Request channel.
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [CHIP_W-1:0]  s_chip_index,
    input  wire logic [7:0]         s_sample_byte,
    input  wire logic               s_first_read,
    input  wire logic               s_map_layer,
    input  wire logic [POS_W-1:0]   s_map_position,
    input  wire logic [CODE_W-1:0]  s_map_keycode,
    // Result channel.
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CODE_W-1:0]       m_keycode,
    output logic                    m_press,
    output logic [1:0]              m_key_class,
    output logic [IDX_W-1:0]        m_report_index,
    output logic [7:0]              m_report_value,
    output logic                    m_last
);

    logic [POS_W-1:0] fn_position_reg;
    logic             cfg_write;
    kmnr_cmd_t        cmd;
    kmnr_status_t     status;
    logic             frame_xfer;
    logic             walk_done;
    logic             last_out;
    logic             other_out;
    logic             other_clear;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_FN_POSITION) ? PDATA_W'(fn_position_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fn_position_reg <= '0;
        end else if (cfg_write && (paddr == ADDR_FN_POSITION)) begin
            fn_position_reg <= pwdata[POS_W-1:0];
        end
    end

    kmnr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .status     (status),
        .cmd        (cmd)
    );

    kmnr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .fn_position    (fn_position_reg),
        .s_chip_index   (s_chip_index),
        .s_sample_byte  (s_sample_byte),
        .s_first_read   (s_first_read),
        .s_map_layer    (s_map_layer),
        .s_map_position (s_map_position),
        .s_map_keycode  (s_map_keycode),
        .m_keycode      (m_keycode),
        .m_press        (m_press),
        .m_key_class    (m_key_class),
        .m_report_index (m_report_index),
        .m_report_value (m_report_value),
        .m_last         (m_last)
    );

    // Conditions watched by the assertions.
    assign frame_xfer  = s_valid && s_ready && (s_req_type == REQ_FRAME_END);
    assign walk_done   = cmd.emit && !status.any_diff;
    assign last_out    = m_valid && m_last;
    assign other_out   = m_valid && (m_key_class == CLASS_OTHER);
    assign other_clear = (m_report_index == '0) && (m_report_value == '0);

    // A new result is only loaded when the result register is free.
    `KMNR_ASSERT_SAME(a_emit_into_free, cmd.emit, (!m_valid || m_ready), "result overwritten")

    // A frame end stops further requests until its walk is done.
    `KMNR_ASSERT_NEXT(a_frame_blocks, frame_xfer, !s_ready, "request taken during a walk")

    // After the final change of a frame the block takes requests again.
    `KMNR_ASSERT_NEXT(a_last_releases, walk_done, (s_ready && last_out), "walk end not flagged")

    // Ignored keycodes always carry a zero report index and report value.
    `KMNR_ASSERT_SAME(a_other_zero, other_out, other_clear, "ignored key has report data")

endmodule

`default_nettype wire
